FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the heartbeat rate detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define HRD_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition leads to a consequence at the same edge.
`define HRD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition leads to a consequence at the next edge.
`define HRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/hrd_pkg.sv
// Types, constants and register map of the heartbeat rate detector.
package hrd_pkg;

  // Field and counter widths
  localparam int PERIOD_BITS = 16;
  localparam int SAMPLE_W    = 10;
  localparam int HOLD_W      = 8;
  localparam int RATE_W      = 16;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;
  localparam int DIV_CNT_W   = $clog2(RATE_W);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;
  localparam logic [RATE_W-1:0]      RATE_SAT   = '1;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_HIGH_THR  = 2'd0;
  localparam logic [1:0] REG_LOW_THR   = 2'd1;
  localparam logic [1:0] REG_HOLD      = 2'd2;
  localparam logic [1:0] REG_RATE_CONST = 2'd3;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] HIGH_THR_RST   = 10'd93;
  localparam logic [SAMPLE_W-1:0] LOW_THR_RST    = 10'd62;
  localparam logic [HOLD_W-1:0]   HOLD_RST       = 8'd10;
  localparam logic [RATE_W-1:0]   RATE_CONST_RST = 16'd60000;

  // One classified sample, handed from front to back
  typedef struct packed {
    logic                   beat;
    logic                   rate_valid;
    logic                   lit;
    logic [PERIOD_BITS-1:0] period;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } back_state_t;

endpackage

FILE: rtl/core/hrd_front.sv
// Front end: beat detection with hysteresis, period counter and indicator hold.
`include "assert_macros.svh"
module hrd_front import hrd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [SAMPLE_W-1:0] high_thr,
  input  logic [SAMPLE_W-1:0] low_thr,
  input  logic [HOLD_W-1:0]   hold_cfg,
  input  logic                q_ready,
  output logic                q_push,
  output job_t                q_job
);

  logic                   disarmed_r, disarmed_nxt;
  logic                   seen_r, seen_nxt;
  logic [PERIOD_BITS-1:0] ticks_r, ticks_nxt;
  logic [HOLD_W-1:0]      hold_r, hold_nxt;
  logic                   still_disarmed;
  logic                   is_beat;
  logic [PERIOD_BITS-1:0] ticks_base;

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  // Classify the sample: re-arm check first, then beat check
  always_comb begin
    still_disarmed = disarmed_r & ~(in_sample < low_thr);
    is_beat        = (in_sample > high_thr) & ~still_disarmed;

    q_job.beat       = is_beat;
    q_job.rate_valid = is_beat & seen_r;
    q_job.period     = ticks_r;
    q_job.lit        = is_beat | (hold_r != '0);

    if (is_beat) begin
      seen_nxt     = 1'b1;
      disarmed_nxt = 1'b1;
      ticks_base   = '0;
      hold_nxt     = hold_cfg;
    end else begin
      seen_nxt     = seen_r;
      disarmed_nxt = still_disarmed;
      ticks_base   = ticks_r;
      hold_nxt     = (hold_r != '0) ? hold_r - 1'b1 : hold_r;
    end

    // Advance the tick counter, saturating at its limit
    ticks_nxt = (ticks_base != PERIOD_MAX) ? ticks_base + 1'b1 : ticks_base;
  end

  // Update detector state on every accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disarmed_r <= 1'b0;
      seen_r     <= 1'b0;
      ticks_r    <= '0;
      hold_r     <= '0;
    end else if (q_push) begin
      disarmed_r <= disarmed_nxt;
      seen_r     <= seen_nxt;
      ticks_r    <= ticks_nxt;
      hold_r     <= hold_nxt;
    end
  end

  `HRD_ASSERT_NEXT(a_beat_disarms, q_push && is_beat, disarmed_r && seen_r, "beat must disarm and mark seen")

endmodule

FILE: rtl/core/hrd_queue.sv
// Short queue of classified items between front and back.
`include "assert_macros.svh"
module hrd_queue import hrd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `HRD_ASSERT(a_count_bound, count_r <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `HRD_ASSERT_IMPL(a_no_overflow, push, push_ready, "push into full queue")
  `HRD_ASSERT_IMPL(a_no_underflow, pop, pop_valid, "pop from empty queue")

endmodule

FILE: rtl/core/hrd_back.sv
// Back end: bit-serial rate division and the result register.
`include "assert_macros.svh"
module hrd_back import hrd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  job_t              q_job,
  output logic              q_pop,
  input  logic [RATE_W-1:0] rate_const,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_beat,
  output logic              out_rate_valid,
  output logic [RATE_W-1:0] out_rate_tenths,
  output logic              out_indicator_on
);

  back_state_t            state_r, state_nxt;
  logic                   beat_r, beat_nxt;
  logic                   rv_r, rv_nxt;
  logic                   lit_r, lit_nxt;
  logic [PERIOD_BITS-1:0] div_r, div_nxt;
  logic [PERIOD_BITS-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0]      quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PERIOD_BITS:0]   trial;
  logic [PERIOD_BITS:0]   diff;
  logic                   fits;

  // One restoring-division step: shift in the next dividend bit
  always_comb begin
    trial = {rem_r, quo_r[RATE_W-1]};
    diff  = trial - {1'b0, div_r};
    fits  = (trial >= {1'b0, div_r});
  end

  // Sequence: take an item, divide if needed, present the result
  always_comb begin
    state_nxt = state_r;
    beat_nxt  = beat_r;
    rv_nxt    = rv_r;
    lit_nxt   = lit_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          beat_nxt = q_job.beat;
          rv_nxt   = q_job.rate_valid;
          lit_nxt  = q_job.lit;
          div_nxt  = q_job.period;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          if (q_job.rate_valid && (q_job.period != '0)) begin
            quo_nxt   = rate_const;
            state_nxt = ST_DIV;
          end else begin
            quo_nxt   = q_job.rate_valid ? RATE_SAT : '0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = fits ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
        quo_nxt = {quo_r[RATE_W-2:0], fits};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(RATE_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload and divider registers
  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
    rv_r   <= rv_nxt;
    lit_r  <= lit_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign out_valid        = (state_r == ST_DONE);
  assign out_beat         = beat_r;
  assign out_rate_valid   = rv_r;
  assign out_rate_tenths  = quo_r;
  assign out_indicator_on = lit_r;

  `HRD_ASSERT_IMPL(a_rate_zero, out_valid && !out_rate_valid, out_rate_tenths == '0, "rate without valid period")
  `HRD_ASSERT_NEXT(a_div_ends, (state_r == ST_DIV) && (cnt_r == DIV_CNT_W'(RATE_W - 1)), state_r == ST_DONE, "division overran")

endmodule

FILE: rtl/core/heartbeat_rate_detector_top.sv
// Top level of the heartbeat rate detector: register file and block wiring.
//
//   Port group   Direction  Handshake                Payload
//   in_*         in         in_valid / in_ready      in_sample
//   out_*        out        out_valid / out_ready    out_beat, out_rate_valid,
//                                                    out_rate_tenths, out_indicator_on
//   APB          in/out     psel, penable, pready    paddr, pwdata, prdata
//
// The front classifies a sample in the cycle it is accepted and queues it (two entries).
// The back takes an item from the queue, runs the serial divider when a rate is due, and
// presents the result until out_ready; it takes no new item before the result is taken,
// so the divider bounds the sustained rate of items that carry a rate.
// Reset is synchronous on rst_n; a stalled out_ready fills the queue and then drops in_ready.
module heartbeat_rate_detector_top import hrd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_beat,
  output logic                out_rate_valid,
  output logic [RATE_W-1:0]   out_rate_tenths,
  output logic                out_indicator_on,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic [SAMPLE_W-1:0] high_thr_r;
  logic [SAMPLE_W-1:0] low_thr_r;
  logic [HOLD_W-1:0]   hold_r;
  logic [RATE_W-1:0]   rate_const_r;
  logic [1:0]          reg_idx;
  logic                wr_en;
  logic                q_push, q_push_ready, q_pop, q_valid;
  job_t                push_job, pop_job;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r   <= HIGH_THR_RST;
      low_thr_r    <= LOW_THR_RST;
      hold_r       <= HOLD_RST;
      rate_const_r <= RATE_CONST_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HIGH_THR:   high_thr_r   <= pwdata[SAMPLE_W-1:0];
        REG_LOW_THR:    low_thr_r    <= pwdata[SAMPLE_W-1:0];
        REG_HOLD:       hold_r       <= pwdata[HOLD_W-1:0];
        REG_RATE_CONST: rate_const_r <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_idx)
      REG_HIGH_THR:   prdata = PDATA_W'(high_thr_r);
      REG_LOW_THR:    prdata = PDATA_W'(low_thr_r);
      REG_HOLD:       prdata = PDATA_W'(hold_r);
      REG_RATE_CONST: prdata = PDATA_W'(rate_const_r);
      default:        prdata = '0;
    endcase
  end

  hrd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .high_thr  (high_thr_r),
    .low_thr   (low_thr_r),
    .hold_cfg  (hold_r),
    .q_ready   (q_push_ready),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  hrd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_job    (pop_job)
  );

  hrd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_job            (pop_job),
    .q_pop            (q_pop),
    .rate_const       (rate_const_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_beat         (out_beat),
    .out_rate_valid   (out_rate_valid),
    .out_rate_tenths  (out_rate_tenths),
    .out_indicator_on (out_indicator_on)
  );

endmodule

FILE: tb/heartbeat_rate_detector_top_test.sv
// Self-checking testbench for the heartbeat rate detector top level.
`timescale 1ns / 100ps

module heartbeat_rate_detector_top_test;
  import hrd_pkg::*;

  // One reading as the block presents it
  typedef struct packed {
    logic              beat;
    logic              rate_valid;
    logic [RATE_W-1:0] rate_tenths;
    logic              indicator_on;
  } reading_t;

  // Mirror the detector, queue predicted readings and check the real ones
  class beat_rate_scoreboard;
    logic [SAMPLE_W-1:0]    high_thr;
    logic [SAMPLE_W-1:0]    low_thr;
    logic [HOLD_W-1:0]      hold;
    logic [RATE_W-1:0]      rate_const;
    bit                     disarmed;
    bit                     seen_beat;
    logic [PERIOD_BITS-1:0] ticks;
    logic [HOLD_W-1:0]      hold_left;
    reading_t               expected_readings[$];
    int                     mismatches;

    function new();
      high_thr   = HIGH_THR_RST;
      low_thr    = LOW_THR_RST;
      hold       = HOLD_RST;
      rate_const = RATE_CONST_RST;
      disarmed   = 1'b0;
      seen_beat  = 1'b0;
      ticks      = '0;
      hold_left  = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_HIGH_THR:   high_thr   = value[SAMPLE_W-1:0];
        REG_LOW_THR:    low_thr    = value[SAMPLE_W-1:0];
        REG_HOLD:       hold       = value[HOLD_W-1:0];
        REG_RATE_CONST: rate_const = value[RATE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      reading_t r;
      r = '0;
      // Re-arm first, then look for a beat
      if (s < low_thr) disarmed = 1'b0;
      if (s > high_thr && !disarmed) begin
        r.beat = 1'b1;
        if (seen_beat) begin
          r.rate_valid  = 1'b1;
          r.rate_tenths = (ticks == '0) ? RATE_SAT : rate_const / ticks;
        end
        seen_beat      = 1'b1;
        disarmed       = 1'b1;
        ticks          = '0;
        hold_left      = hold;
        r.indicator_on = 1'b1;
      end else if (hold_left != '0) begin
        r.indicator_on = 1'b1;
        hold_left      = hold_left - 1'b1;
      end
      // Advance the period counter, saturating
      if (ticks != PERIOD_MAX) ticks = ticks + 1'b1;
      expected_readings.push_back(r);
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading: beat %0b valid %0b rate %0d lit %0b",
                   got.beat, got.rate_valid, got.rate_tenths, got.indicator_on);
        return;
      end
      want = expected_readings.pop_front();
      if (got.beat !== want.beat || got.rate_valid !== want.rate_valid ||
          got.rate_tenths !== want.rate_tenths || got.indicator_on !== want.indicator_on) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"reading mismatch: expected beat %0b valid %0b rate %0d lit %0b,",
                    " got beat %0b valid %0b rate %0d lit %0b"},
                   want.beat, want.rate_valid, want.rate_tenths, want.indicator_on,
                   got.beat, got.rate_valid, got.rate_tenths, got.indicator_on);
      end
    endfunction
  endclass

  bit                  clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample;
  logic                out_valid;
  logic                out_ready;
  logic                out_beat;
  logic                out_rate_valid;
  logic [RATE_W-1:0]   out_rate_tenths;
  logic                out_indicator_on;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  bit steady          = 1'b0;
  bit long_stall_due  = 1'b0;
  bit long_stall_done = 1'b0;

  beat_rate_scoreboard sb = new();

  heartbeat_rate_detector_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_beat         (out_beat),
    .out_rate_valid   (out_rate_valid),
    .out_rate_tenths  (out_rate_tenths),
    .out_indicator_on (out_indicator_on),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Observe handshakes and register writes on the edge
  always @(posedge clk) begin
    if (rst_n && psel && penable && pwrite && pready)
      sb.set_register(paddr[3:2], pwdata);
    if (rst_n && in_valid && in_ready)
      sb.note_sample(in_sample);
    if (rst_n && out_valid && out_ready)
      sb.check_reading({out_beat, out_rate_valid, out_rate_tenths, out_indicator_on});
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_stall_due && !long_stall_done) begin
        long_stall_done = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (steady ? 16 : $urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Offer one sample and hold it until accepted
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = steady ? 0 : ($urandom_range(0, 1) == 1 ? gap_len() : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let the last accepted item be noted, then wait for every reading
  task automatic wait_drained();
    @(posedge clk);
    while (sb.expected_readings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the block, then load all four registers with junk in the unused bits
  task automatic configure(input int hi, input int lo, input int hold_n, input int rc);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(REG_HIGH_THR,   {22'($urandom), SAMPLE_W'(hi)});
    write_reg(REG_LOW_THR,    {22'($urandom), SAMPLE_W'(lo)});
    write_reg(REG_HOLD,       {24'($urandom), HOLD_W'(hold_n)});
    write_reg(REG_RATE_CONST, {16'($urandom), RATE_W'(rc)});
  endtask

  // Mostly whole heartbeats (baseline, peak, settle), some plain noise
  task automatic send_random(input int count);
    int sent, n, k, lo, hi;
    sent = 0;
    while (sent < count) begin
      lo = sb.low_thr;
      hi = sb.high_thr;
      if ($urandom_range(0, 99) < 85) begin
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++)
          send_sample(lo == 0 ? '0 : SAMPLE_W'($urandom_range(0, lo - 1)));
        sent += n;
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++)
          send_sample(hi == 1023 ? '1 : SAMPLE_W'($urandom_range(hi + 1, 1023)));
        sent += n;
        n = $urandom_range(0, 5);
        for (k = 0; k < n; k++)
          send_sample(SAMPLE_W'($urandom_range(lo, hi)));
        sent += n;
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          send_sample(SAMPLE_W'($urandom_range(0, 1023)));
        sent += n;
      end
    end
  endtask

  initial begin
    int lo, hi;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: first beat without rate, hysteresis edges, retrigger
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd1023);
    send_sample(10'd93);
    send_sample(10'd62);
    send_sample(10'd61);
    send_sample(10'd94);
    send_sample(10'd50);
    send_sample(10'd94);
    send_sample(10'd512);
    send_sample(10'd341);
    send_sample(10'd682);
    send_sample(10'd0);

    // Crossed thresholds: re-arm and beat in one sample
    configure(0, 1023, 255, 65535);
    send_sample(10'd1022);
    send_sample(10'd1);
    send_sample(10'd1023);
    send_sample(10'd0);
    send_sample(10'd5);

    // Zero rate constant, no extra indicator samples
    configure(200, 100, 0, 0);
    send_sample(10'd300);
    send_sample(10'd50);
    send_sample(10'd300);
    send_sample(10'd1023);

    // Thresholds at the ends of the range: never beats
    configure(1023, 0, 10, 1);
    send_sample(10'd1023);
    send_sample(10'd0);

    // Random phases across several settings
    configure(1022, 1, 255, 65535);
    send_random(100);

    lo = $urandom_range(0, 500);
    hi = $urandom_range(lo, 1000);
    configure(hi, lo, $urandom_range(0, 255), $urandom_range(1, 65535));
    long_stall_due = 1'b1;
    send_random(100);

    lo = $urandom_range(0, 500);
    hi = $urandom_range(lo, 1000);
    configure(hi, lo, 0, 1);
    send_random(100);

    hi = $urandom_range(0, 400);
    lo = $urandom_range(hi + 1, 1023);
    configure(hi, lo, $urandom_range(0, 255), $urandom_range(1, 65535));
    send_random(100);

    lo = $urandom_range(0, 500);
    hi = $urandom_range(lo, 1000);
    configure(hi, lo, $urandom_range(0, 255), $urandom_range(1, 65535));
    steady = 1'b1;
    send_random(50);
    steady = 1'b0;
    send_random(50);

    in_valid <= 1'b0;
    wait_drained();
    if (sb.mismatches == 0 && sb.expected_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
